FILE: rtl/rational_arithmetic_unit_core_defines.svh
// assertion macros for the rational arithmetic unit
// no dependencies
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
// condition or implication checked on every clock, held off in reset
`define RAU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RAU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

FILE: rtl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
// no dependencies
`default_nettype none
package rau_pkg;
  localparam int WordBits = 64;
  localparam int CntBits = 7;
  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_CMP = 3'd4, OP_RED = 3'd5, OP_RCP = 3'd6, OP_ABS = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_ZDEN = 2'd2;

  // arithmetic unit commands
  typedef enum logic [1:0] {
    CMD_MUL = 2'd0, CMD_DIV = 2'd1, CMD_GCD = 2'd2
  } cmd_t;

  typedef struct packed {
    logic start;
    cmd_t cmd;
  } au_ctl_t;

  function automatic word_t mag(input word_t v);
    mag = v[WordBits-1] ? (~v + 1'b1) : v;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/rau_serial_unit.sv
// bit-serial multiplier, divider and gcd unit, one bit per cycle
// depends on rau_pkg
`default_nettype none
module rau_serial_unit import rau_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire au_ctl_t ctl,
  input  wire word_t op_a,
  input  wire word_t op_b,
  output logic       done,
  output word_t      res
);
  // mul: res = a*b wrapped; div: res = a/b unsigned; gcd: res = gcd(a,b) unsigned
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_DIV = 4'b0100, S_GCD = 4'b1000
  } st_t;

  st_t st_r, st_nxt;
  word_t x_r, x_nxt, y_r, y_nxt, acc_r, acc_nxt, rem_r, rem_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic gcd_div_r, gcd_div_nxt;
  logic done_r, done_nxt;
  logic [WordBits:0] trial;

  always_comb begin
    st_nxt = st_r;
    x_nxt = x_r;
    y_nxt = y_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    gcd_div_nxt = gcd_div_r;
    done_nxt = 1'b0;
    trial = {rem_r[WordBits-2:0], acc_r[WordBits-1], 1'b0} >> 1;
    trial = {rem_r, acc_r[WordBits-1]} - {1'b0, y_r};
    unique case (st_r)
      S_IDLE: begin
        if (ctl.start) begin
          x_nxt = op_a;
          y_nxt = op_b;
          cnt_nxt = '0;
          rem_nxt = '0;
          case (ctl.cmd)
            CMD_MUL: begin
              acc_nxt = '0;
              st_nxt = S_MUL;
            end
            CMD_DIV: begin
              acc_nxt = op_a;
              st_nxt = S_DIV;
            end
            default: begin
              gcd_div_nxt = 1'b0;
              st_nxt = S_GCD;
            end
          endcase
        end
      end
      S_MUL: begin
        if (y_r[0]) acc_nxt = acc_r + x_r;
        x_nxt = x_r << 1;
        y_nxt = y_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntBits'(WordBits - 1)) begin
          st_nxt = S_IDLE;
          done_nxt = 1'b1;
        end
      end
      S_DIV: begin
        // restoring long division, quotient shifts into acc
        if (!trial[WordBits]) begin
          rem_nxt = trial[WordBits-1:0];
          acc_nxt = {acc_r[WordBits-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[WordBits-2:0], acc_r[WordBits-1]};
          acc_nxt = {acc_r[WordBits-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntBits'(WordBits - 1)) begin
          st_nxt = S_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: begin
        // euclid: x, y held; each step divides x by y serially
        if (!gcd_div_r) begin
          if (y_r == '0) begin
            acc_nxt = x_r;
            st_nxt = S_IDLE;
            done_nxt = 1'b1;
          end else begin
            acc_nxt = x_r;
            rem_nxt = '0;
            cnt_nxt = '0;
            gcd_div_nxt = 1'b1;
          end
        end else begin
          if (!trial[WordBits]) begin
            rem_nxt = trial[WordBits-1:0];
          end else begin
            rem_nxt = {rem_r[WordBits-2:0], acc_r[WordBits-1]};
          end
          acc_nxt = acc_r << 1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CntBits'(WordBits - 1)) begin
            x_nxt = y_r;
            y_nxt = rem_nxt;
            gcd_div_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done_r <= 1'b0;
      gcd_div_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
      gcd_div_r <= gcd_div_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign res = acc_r;
endmodule
`default_nettype wire

FILE: rtl/rational_arithmetic_unit_core.sv
// rational arithmetic unit top level: operation sequencer around one serial unit
// depends on rau_pkg, rau_serial_unit and rational_arithmetic_unit_core_defines.svh
//
//  channel | dir | handshake          | payload
//  in      | in  | in_tvalid/tready   | in_tdata: operation, a_num, a_den, b_num, b_den
//  out     | out | out_tvalid/tready  | out_tdata: res_num, res_den; out_tuser: flags, status
//
// one item at a time; a multiply or divide step goes through issue, the serial bits, done
// and capture, and a gcd runs euclid iterations, up to about 92 on 64-bit magnitudes; an
// error or a compare of equal denominators skips the serial unit, and an add or sub runs
// three gcds
// synchronous active-low reset returns the sequencer to idle
// the result waits in the output register; the next item is taken once it is taken
`default_nettype none
`include "rational_arithmetic_unit_core_defines.svh"
module rational_arithmetic_unit_core import rau_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // operation[2:0], a_num[66:3], a_den[130:67], b_num[194:131], b_den[258:195], zero pad
  input  wire logic [263:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // res_num[63:0], res_den[127:64]
  output logic [127:0]      out_tdata,
  // is_less[0], is_equal[1], is_greater[2], status[4:3]
  output logic [4:0]        out_tuser
);
  typedef enum logic [4:0] {
    P_IDLE = 5'b00001, P_ISSUE = 5'b00010, P_WAIT = 5'b00100,
    P_DONE = 5'b01000, P_OUT = 5'b10000
  } ph_t;

  ph_t ph_r, ph_nxt;
  logic [4:0] stp_r, stp_nxt;
  op_t op_r, op_nxt;
  word_t an_r, ad_r, bn_r, bd_r, an_nxt, ad_nxt, bn_nxt, bd_nxt;
  word_t g_r, g_nxt, h_r, h_nxt, rn_r, rn_nxt, rd_r, rd_nxt;
  word_t t1_r, t1_nxt, t2_r, t2_nxt;
  logic [1:0] st_r, st_nxt;
  logic [2:0] flg_r, flg_nxt;
  logic sw_r, sw_nxt;
  au_ctl_t ctl;
  word_t ua, ub, ures;
  logic udone;

  // divx operands: sign of dividend kept in ds_r
  logic ds_r, ds_nxt;

  rau_serial_unit u_su (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .op_a(ua), .op_b(ub),
    .done(udone), .res(ures)
  );

  function automatic logic slt(input word_t a, input word_t b);
    slt = $signed(a) < $signed(b);
  endfunction

  word_t sq;
  assign sq = ds_r ? (~ures + 1'b1) : ures;

  // sequence of steps; each issue sets ua/ub/cmd, each done consumes result
  always_comb begin
    ph_nxt = ph_r; stp_nxt = stp_r; op_nxt = op_r;
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    g_nxt = g_r; h_nxt = h_r; rn_nxt = rn_r; rd_nxt = rd_r;
    t1_nxt = t1_r; t2_nxt = t2_r; st_nxt = st_r; flg_nxt = flg_r;
    sw_nxt = sw_r; ds_nxt = ds_r;
    ctl = '{start: 1'b0, cmd: CMD_GCD};
    ua = '0; ub = '0;
    unique case (ph_r)
      P_IDLE: begin
        if (in_tvalid) begin
          op_nxt = op_t'(in_tdata[2:0]);
          an_nxt = in_tdata[66:3]; ad_nxt = in_tdata[130:67];
          bn_nxt = in_tdata[194:131]; bd_nxt = in_tdata[258:195];
          stp_nxt = '0; st_nxt = ST_OK; flg_nxt = '0;
          rn_nxt = '0; rd_nxt = '0;
          ph_nxt = P_DONE;
          stp_nxt = 5'd31; // setup step
        end
      end
      P_ISSUE: begin
        ctl.start = 1'b1;
        ph_nxt = P_WAIT;
        case (stp_r)
          // add/sub: 0 g=gcd(ad,bd) 1 bd/g 2 an*t1 3 ad/g 4 bn*t2
          5'd0: begin ctl.cmd = CMD_GCD; ua = mag(ad_r); ub = mag(bd_r); end
          5'd1: begin ctl.cmd = CMD_DIV; ua = mag(bd_r); ub = g_r; end
          5'd2: begin ctl.cmd = CMD_MUL; ua = an_r; ub = t1_r; end
          5'd3: begin ctl.cmd = CMD_DIV; ua = mag(ad_r); ub = g_r; end
          5'd4: begin ctl.cmd = CMD_MUL; ua = bn_r; ub = t2_r; end
          // 5 h=gcd(rn, sw?bd:ad) 6 rn/h 7 other/h 8 d1*d2
          5'd5: begin ctl.cmd = CMD_GCD; ua = mag(rn_r); ub = mag(sw_r ? bd_r : ad_r); end
          5'd6: begin ctl.cmd = CMD_DIV; ua = mag(rn_r); ub = h_r; end
          5'd7: begin ctl.cmd = CMD_DIV; ua = mag(sw_r ? bd_r : ad_r); ub = h_r; end
          5'd8: begin ctl.cmd = CMD_MUL; ua = t1_r; ub = t2_r; end
          // mul/div: 10 g=gcd(an,x1) 11 an/g 12 x1/g 13 h=gcd(x2,ad) 14 x2/h 15 ad/h
          // 16 n1*n2 17 d1*d2
          5'd10: begin ctl.cmd = CMD_GCD; ua = mag(an_r); ub = mag(bd_r); end
          5'd11: begin ctl.cmd = CMD_DIV; ua = mag(an_r); ub = g_r; end
          5'd12: begin ctl.cmd = CMD_DIV; ua = mag(bd_r); ub = g_r; end
          5'd13: begin ctl.cmd = CMD_GCD; ua = mag(bn_r); ub = mag(ad_r); end
          5'd14: begin ctl.cmd = CMD_DIV; ua = mag(bn_r); ub = h_r; end
          5'd15: begin ctl.cmd = CMD_DIV; ua = mag(ad_r); ub = h_r; end
          5'd16: begin ctl.cmd = CMD_MUL; ua = an_r; ub = bn_r; end
          5'd17: begin ctl.cmd = CMD_MUL; ua = ad_r; ub = bd_r; end
          // compare: 20 g 21 bd/g 22 *an 23 ad/g 24 *bn
          5'd20: begin ctl.cmd = CMD_GCD; ua = mag(ad_r); ub = mag(bd_r); end
          5'd21: begin ctl.cmd = CMD_DIV; ua = mag(bd_r); ub = g_r; end
          5'd22: begin ctl.cmd = CMD_MUL; ua = t1_r; ub = an_r; end
          5'd23: begin ctl.cmd = CMD_DIV; ua = mag(ad_r); ub = g_r; end
          5'd24: begin ctl.cmd = CMD_MUL; ua = t1_r; ub = bn_r; end
          // reduce: 26 g=gcd(rn,rd) 27 rn/g 28 rd/g
          5'd26: begin ctl.cmd = CMD_GCD; ua = mag(rn_r); ub = mag(rd_r); end
          5'd27: begin ctl.cmd = CMD_DIV; ua = mag(rn_r); ub = g_r; end
          5'd28: begin ctl.cmd = CMD_DIV; ua = mag(rd_r); ub = g_r; end
          default: begin ctl.cmd = CMD_GCD; end
        endcase
        // sign of dividend for signed exact division
        case (stp_r)
          5'd1, 5'd21: ds_nxt = bd_r[WordBits-1];
          5'd3, 5'd23: ds_nxt = ad_r[WordBits-1];
          5'd6: ds_nxt = rn_r[WordBits-1];
          5'd7: ds_nxt = sw_r ? bd_r[WordBits-1] : ad_r[WordBits-1];
          5'd11: ds_nxt = an_r[WordBits-1];
          5'd12: ds_nxt = bd_r[WordBits-1];
          5'd14: ds_nxt = bn_r[WordBits-1];
          5'd15: ds_nxt = ad_r[WordBits-1];
          5'd27: ds_nxt = rn_r[WordBits-1];
          5'd28: ds_nxt = rd_r[WordBits-1];
          default: ds_nxt = 1'b0;
        endcase
      end
      P_WAIT: begin
        if (udone) ph_nxt = P_DONE;
      end
      P_DONE: begin
        ph_nxt = P_ISSUE;
        stp_nxt = stp_r + 1'b1;
        case (stp_r)
          5'd31: begin
            // dispatch after capture
            if (op_r == OP_CMP) begin
              if (ad_r == bd_r) begin
                t1_nxt = an_r; t2_nxt = bn_r; stp_nxt = 5'd25;
                ph_nxt = P_DONE;
              end else stp_nxt = 5'd20;
            end else if (ad_r == '0 || (op_r <= OP_DIV && bd_r == '0)) begin
              st_nxt = ST_ZDEN; ph_nxt = P_OUT;
            end else if ((op_r == OP_DIV && bn_r == '0) || (op_r == OP_RCP && an_r == '0)) begin
              st_nxt = ST_DIV0; ph_nxt = P_OUT;
            end else if (op_r <= OP_SUB) begin
              stp_nxt = 5'd0;
            end else if (op_r <= OP_DIV) begin
              if (op_r == OP_DIV) begin
                bd_nxt = bn_r; bn_nxt = bd_r;
              end
              stp_nxt = 5'd10;
            end else begin
              rn_nxt = an_r; rd_nxt = ad_r;
              if (op_r == OP_RCP) begin
                rn_nxt = ad_r; rd_nxt = an_r;
              end else if (op_r == OP_ABS) begin
                rn_nxt = mag(an_r); rd_nxt = mag(ad_r);
              end
              ph_nxt = P_DONE; stp_nxt = 5'd29;
            end
          end
          5'd0: g_nxt = ures;
          5'd1: t1_nxt = sq;
          5'd2: begin rn_nxt = ures; end
          5'd3: t2_nxt = sq;
          5'd4: begin
            rn_nxt = (op_r == OP_ADD) ? rn_r + ures : rn_r - ures;
            sw_nxt = slt(bd_r, ad_r);
          end
          5'd5: h_nxt = ures;
          5'd6: rn_nxt = (h_r == '0) ? rn_r : sq;
          5'd7: begin
            // t1 = d1, t2 = d2
            if (sw_r) begin
              t1_nxt = (g_r == '0) ? ad_r : t2_r;
              t2_nxt = (h_r == '0) ? bd_r : sq;
            end else begin
              t2_nxt = (g_r == '0) ? bd_r : t1_r;
              t1_nxt = (h_r == '0) ? ad_r : sq;
            end
          end
          5'd8: begin rd_nxt = ures; stp_nxt = 5'd29; ph_nxt = P_DONE; end
          5'd10: g_nxt = ures;
          5'd11: if (g_r != '0) an_nxt = sq;
          5'd12: if (g_r != '0) bd_nxt = sq;
          5'd13: h_nxt = ures;
          5'd14: if (h_r != '0) bn_nxt = sq;
          5'd15: if (h_r != '0) ad_nxt = sq;
          5'd16: rn_nxt = ures;
          5'd17: begin rd_nxt = ures; stp_nxt = 5'd29; ph_nxt = P_DONE; end
          5'd20: g_nxt = ures;
          5'd21: t1_nxt = (g_r == '0) ? bd_r : sq;
          5'd22: t2_nxt = ures;
          5'd23: t1_nxt = (g_r == '0) ? ad_r : sq;
          5'd24: begin
            t1_nxt = t2_r; t2_nxt = ures; stp_nxt = 5'd25; ph_nxt = P_DONE;
          end
          5'd25: begin
            flg_nxt = {slt(t2_r, t1_r), t1_r == t2_r, slt(t1_r, t2_r)};
            ph_nxt = P_OUT;
          end
          5'd29: begin
            if (rd_r == '0) begin
              st_nxt = ST_ZDEN; ph_nxt = P_OUT;
            end else stp_nxt = 5'd26;
          end
          5'd26: g_nxt = ures;
          5'd27: if (g_r != '0) rn_nxt = sq;
          5'd28: begin
            if (g_r != '0) rd_nxt = sq;
            ph_nxt = P_OUT;
            if ((g_r != '0) ? sq[WordBits-1] : rd_r[WordBits-1]) begin
              rd_nxt = ~((g_r != '0) ? sq : rd_r) + 1'b1;
              rn_nxt = ~rn_r + 1'b1;
            end
          end
          default: ph_nxt = P_OUT;
        endcase
      end
      default: begin
        if (out_tready) ph_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ph_r <= P_IDLE;
    else ph_r <= ph_nxt;
    stp_r <= stp_nxt; op_r <= op_nxt;
    an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    g_r <= g_nxt; h_r <= h_nxt; rn_r <= rn_nxt; rd_r <= rd_nxt;
    t1_r <= t1_nxt; t2_r <= t2_nxt; st_r <= st_nxt; flg_r <= flg_nxt;
    sw_r <= sw_nxt; ds_r <= ds_nxt;
  end

  assign in_tready = (ph_r == P_IDLE);
  assign out_tvalid = (ph_r == P_OUT);
  assign out_tdata = {rd_r, rn_r};
  assign out_tuser = {st_r, flg_r[2], flg_r[1], flg_r[0]};

  `RAU_ASSERT(a_flags_onehot0, !out_tvalid || $onehot0(flg_r), "more than one compare flag")
  `RAU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `RAU_ASSERT(a_no_overlap, !(in_tready && out_tvalid), "input taken during output")
endmodule
`default_nettype wire
